// File: hw/rtl/hsh_pkg.sv
// Shared types and constants for the hopscotch hash table block.
`timescale 1ns / 1ps

package hsh_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned OCC_W   = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_PRESENT  = 3'd1,
    STAT_FOUND    = 3'd2,
    STAT_ABSENT   = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_BADKEY   = 3'd5
  } status_e;

  // What a scan pass compares against, and the sweep of the whole store
  typedef enum logic [1:0] {
    SCAN_FIND  = 2'd0,
    SCAN_FREE  = 2'd1,
    SCAN_HOP   = 2'd2,
    SCAN_SWEEP = 2'd3
  } scan_mode_e;

  typedef enum logic [2:0] {
    WR_NONE     = 3'd0,
    WR_SWEEP    = 3'd1,
    WR_UPDATE   = 3'd2,
    WR_ZERO_TAG = 3'd3,
    WR_MOVE     = 3'd4,
    WR_ZERO_SRC = 3'd5,
    WR_NEW      = 3'd6
  } wr_op_e;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e;

  typedef enum logic [1:0] {
    SLOT_ZERO = 2'd0,
    SLOT_TAG  = 2'd1,
    SLOT_POS  = 2'd2
  } slot_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       req_load;
    logic       scan_start;
    scan_mode_e scan_mode;
    logic       scan_en;
    logic       sweep;
    wr_op_e     wr_op;
    cnt_op_e    cnt_op;
    logic       pos_from_tag;
    logic       src_from_tag;
    logic       pos_from_src;
    logic       res_load;
    status_e    res_status;
    slot_sel_e  res_slot;
    logic       res_val_hit;
    logic       out_load;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_e cmd;
    logic key_zero;
    logic rvalid;
    logic hit;
    logic last;
    logic far;
    logic sweep_last;
  } sts_t;

endpackage

// File: hw/rtl/hsh_req_if.sv
// Request and response channel interfaces of the hash table.
`timescale 1ns / 1ps

interface hsh_req_if;
  logic                             valid;
  logic                             ready;
  logic [hsh_pkg::CMD_W-1:0]        command;
  logic signed [hsh_pkg::KEY_W-1:0] key;
  logic [hsh_pkg::VALUE_W-1:0]      value_in;

  modport source (output valid, output command, output key, output value_in, input ready);
  modport sink   (input valid, input command, input key, input value_in, output ready);
endinterface

interface hsh_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [hsh_pkg::STAT_W-1:0]  status;
  logic [hsh_pkg::SLOT_W-1:0]  slot;
  logic [hsh_pkg::VALUE_W-1:0] value_out;
  logic [hsh_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, output status, output slot, output value_out,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input slot, input value_out,
                  input occupancy, output ready);
endinterface

// File: hw/rtl/hsh_datapath.sv
// Slot store, scan pointer, insert registers and result registers.
`timescale 1ns / 1ps

module hsh_datapath #(
  parameter int unsigned TABLE_SLOTS  = 1024,
  parameter int unsigned NEIGHBORHOOD = 32,
  parameter int unsigned PROBE_WINDOW = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [hsh_pkg::CMD_W-1:0]        req_command_i,
  input  logic signed [hsh_pkg::KEY_W-1:0] req_key_i,
  input  logic [hsh_pkg::VALUE_W-1:0]      req_value_i,
  input  hsh_pkg::ctl_t                    ctl_i,
  output hsh_pkg::sts_t                    sts_o,
  output logic [hsh_pkg::STAT_W-1:0]       out_status_o,
  output logic [hsh_pkg::SLOT_W-1:0]       out_slot_o,
  output logic [hsh_pkg::VALUE_W-1:0]      out_value_o,
  output logic [hsh_pkg::OCC_W-1:0]        out_occ_o
);

  localparam int unsigned KW = hsh_pkg::KEY_W;
  localparam int unsigned VW = hsh_pkg::VALUE_W;
  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned HW = $clog2(NEIGHBORHOOD);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned EW = $clog2(TABLE_SLOTS + PROBE_WINDOW + 1);
  localparam int unsigned WW = KW + HW + VW;

  // Request registers
  hsh_pkg::cmd_e   req_cmd_q;
  logic [KW-1:0]   req_key_q;
  logic [VW-1:0]   req_val_q;

  // Scan and insert state
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [PW-1:0]   end_q, end_d;
  logic [AW-1:0]   tag_q;
  logic            rvalid_q, rvalid_d;
  hsh_pkg::scan_mode_e mode_q;
  logic [AW-1:0]   pos_q, src_q;
  logic [PW-1:0]   count_q, count_d;
  logic [WW-1:0]   rdata_q;
  logic            rd_en;

  // Result holding and output payload
  hsh_pkg::status_e res_status_q;
  logic [AW-1:0]    res_slot_q;
  logic [VW-1:0]    res_value_q;
  logic [hsh_pkg::STAT_W-1:0] out_status_q;
  logic [hsh_pkg::SLOT_W-1:0] out_slot_q;
  logic [VW-1:0]              out_value_q;
  logic [hsh_pkg::OCC_W-1:0]  out_occ_q;

  logic [WW-1:0]   mem_q [TABLE_SLOTS];

  logic [AW-1:0]   home;
  logic [KW-1:0]   rkey;
  logic [HW-1:0]   rhop;
  logic [VW-1:0]   rval;
  logic [PW-1:0]   hop_dist;
  logic [PW-1:0]   hop_sum;
  logic            hit;
  logic [EW-1:0]   end_sum;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [WW-1:0]   wr_data;

  assign home = req_key_q[AW-1:0];
  assign rkey = rdata_q[WW-1 -: KW];
  assign rhop = rdata_q[VW +: HW];
  assign rval = rdata_q[VW-1:0];
  assign hop_dist = PW'(pos_q) - PW'(tag_q);
  assign hop_sum = PW'(rhop) + hop_dist;

  // Match test of the word just read
  always_comb begin
    case (mode_q)
      hsh_pkg::SCAN_FIND: hit = (rkey == req_key_q);
      hsh_pkg::SCAN_FREE: hit = (rkey == '0);
      hsh_pkg::SCAN_HOP:  hit = (hop_sum <= PW'(NEIGHBORHOOD - 1));
      default:            hit = 1'b0;
    endcase
  end

  assign sts_o.cmd        = req_cmd_q;
  assign sts_o.key_zero   = (req_key_q == '0);
  assign sts_o.rvalid     = rvalid_q;
  assign sts_o.hit        = hit;
  assign sts_o.last       = (PW'(tag_q) == end_q - PW'(1));
  assign sts_o.far        = ((PW'(pos_q) - PW'(home)) >= PW'(NEIGHBORHOOD));
  assign sts_o.sweep_last = (ptr_q == PW'(TABLE_SLOTS - 1));

  // Latch the request beat
  always_ff @(posedge clk_i) begin
    if (ctl_i.req_load) begin
      req_cmd_q <= hsh_pkg::cmd_e'(req_command_i);
      req_key_q <= req_key_i;
      req_val_q <= req_value_i;
    end
  end

  // Set the scan range, advance the pointer
  always_comb begin
    ptr_d    = ptr_q;
    end_d    = end_q;
    rvalid_d = 1'b0;
    rd_en    = 1'b0;
    end_sum  = '0;
    if (ctl_i.scan_start) begin
      case (ctl_i.scan_mode)
        hsh_pkg::SCAN_FIND: begin
          ptr_d   = PW'(home);
          end_sum = EW'(home) + EW'(NEIGHBORHOOD);
        end
        hsh_pkg::SCAN_FREE: begin
          ptr_d   = PW'(home);
          end_sum = EW'(home) + EW'(PROBE_WINDOW);
        end
        hsh_pkg::SCAN_HOP: begin
          ptr_d   = PW'(pos_q) - PW'(NEIGHBORHOOD - 1);
          end_sum = EW'(pos_q);
        end
        default: begin
          ptr_d   = '0;
          end_sum = EW'(TABLE_SLOTS);
        end
      endcase
      if (end_sum > EW'(TABLE_SLOTS)) begin
        end_d = PW'(TABLE_SLOTS);
      end else begin
        end_d = PW'(end_sum);
      end
    end else if (ctl_i.sweep) begin
      ptr_d = ptr_q + PW'(1);
    end else if (ctl_i.scan_en && (ptr_q < end_q)) begin
      rd_en    = 1'b1;
      rvalid_d = 1'b1;
      ptr_d    = ptr_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      end_q    <= PW'(TABLE_SLOTS);
      rvalid_q <= 1'b0;
      mode_q   <= hsh_pkg::SCAN_SWEEP;
      count_q  <= '0;
    end else begin
      ptr_q    <= ptr_d;
      end_q    <= end_d;
      rvalid_q <= rvalid_d;
      count_q  <= count_d;
      if (ctl_i.scan_start) begin
        mode_q <= ctl_i.scan_mode;
      end
    end
  end

  // Track the slot of the word in the read register
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      tag_q <= ptr_q[AW-1:0];
    end
    if (ctl_i.pos_from_tag) begin
      pos_q <= tag_q;
    end else if (ctl_i.pos_from_src) begin
      pos_q <= src_q;
    end
    if (ctl_i.src_from_tag) begin
      src_q <= tag_q;
    end
  end

  // Key count
  always_comb begin
    count_d = count_q;
    case (ctl_i.cnt_op)
      hsh_pkg::CNT_INC: count_d = count_q + PW'(1);
      hsh_pkg::CNT_DEC: begin
        if (count_q != '0) begin
          count_d = count_q - PW'(1);
        end
      end
      hsh_pkg::CNT_CLR: count_d = '0;
      default:          count_d = count_q;
    endcase
  end

  // Select the store write
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = tag_q;
    wr_data = '0;
    case (ctl_i.wr_op)
      hsh_pkg::WR_SWEEP:    wr_addr = ptr_q[AW-1:0];
      hsh_pkg::WR_UPDATE:   wr_data = {rkey, rhop, req_val_q};
      hsh_pkg::WR_ZERO_TAG: wr_addr = tag_q;
      hsh_pkg::WR_MOVE: begin
        wr_addr = pos_q;
        wr_data = {rkey, hop_sum[HW-1:0], rval};
      end
      hsh_pkg::WR_ZERO_SRC: wr_addr = src_q;
      hsh_pkg::WR_NEW: begin
        wr_addr = pos_q;
        wr_data = {req_key_q, HW'(pos_q - home), req_val_q};
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Slot store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[ptr_q[AW-1:0]];
    end
  end

  // Hold the result, then move it to the output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      res_status_q <= ctl_i.res_status;
      case (ctl_i.res_slot)
        hsh_pkg::SLOT_TAG: res_slot_q <= tag_q;
        hsh_pkg::SLOT_POS: res_slot_q <= pos_q;
        default:           res_slot_q <= '0;
      endcase
      res_value_q <= ctl_i.res_val_hit ? rval : '0;
    end
    if (ctl_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= hsh_pkg::SLOT_W'(res_slot_q);
      out_value_q  <= res_value_q;
      out_occ_q    <= hsh_pkg::OCC_W'(count_q);
    end
  end

  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_value_o  = out_value_q;
  assign out_occ_o    = out_occ_q;

endmodule

// File: hw/rtl/hsh_controller.sv
// Sequencer for insert, lookup, remove and clear operations.
`timescale 1ns / 1ps

module hsh_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  hsh_pkg::sts_t sts_i,
  output hsh_pkg::ctl_t ctl_o
);

  typedef enum logic [9:0] {
    ST_SWEEP_RST = 10'b00_0000_0001,
    ST_IDLE      = 10'b00_0000_0010,
    ST_DECODE    = 10'b00_0000_0100,
    ST_SWEEP_CLR = 10'b00_0000_1000,
    ST_FIND      = 10'b00_0001_0000,
    ST_FREE      = 10'b00_0010_0000,
    ST_CHECK     = 10'b00_0100_0000,
    ST_HOP       = 10'b00_1000_0000,
    ST_CLR_SRC   = 10'b01_0000_0000,
    ST_DONE      = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  hsh_pkg::ctl_t ctl;

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign ctl_o       = ctl;

  // Next state and datapath commands
  always_comb begin
    state_d          = state_q;
    ctl.req_load     = 1'b0;
    ctl.scan_start   = 1'b0;
    ctl.scan_mode    = hsh_pkg::SCAN_FIND;
    ctl.scan_en      = 1'b0;
    ctl.sweep        = 1'b0;
    ctl.wr_op        = hsh_pkg::WR_NONE;
    ctl.cnt_op       = hsh_pkg::CNT_NONE;
    ctl.pos_from_tag = 1'b0;
    ctl.src_from_tag = 1'b0;
    ctl.pos_from_src = 1'b0;
    ctl.res_load     = 1'b0;
    ctl.res_status   = hsh_pkg::STAT_FOUND;
    ctl.res_slot     = hsh_pkg::SLOT_ZERO;
    ctl.res_val_hit  = 1'b0;
    ctl.out_load     = 1'b0;

    unique case (state_q)
      ST_SWEEP_RST: begin
        ctl.sweep = 1'b1;
        ctl.wr_op = hsh_pkg::WR_SWEEP;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          ctl.req_load = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.cmd == hsh_pkg::CMD_CLEAR) begin
          ctl.scan_start = 1'b1;
          ctl.scan_mode  = hsh_pkg::SCAN_SWEEP;
          state_d        = ST_SWEEP_CLR;
        end else if (sts_i.key_zero) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = hsh_pkg::STAT_BADKEY;
          state_d        = ST_DONE;
        end else begin
          ctl.scan_start = 1'b1;
          ctl.scan_mode  = hsh_pkg::SCAN_FIND;
          state_d        = ST_FIND;
        end
      end
      ST_SWEEP_CLR: begin
        ctl.sweep = 1'b1;
        ctl.wr_op = hsh_pkg::WR_SWEEP;
        if (sts_i.sweep_last) begin
          ctl.cnt_op     = hsh_pkg::CNT_CLR;
          ctl.res_load   = 1'b1;
          ctl.res_status = hsh_pkg::STAT_FOUND;
          state_d        = ST_DONE;
        end
      end
      ST_FIND: begin
        ctl.scan_en = 1'b1;
        if (sts_i.rvalid && sts_i.hit) begin
          ctl.res_load = 1'b1;
          ctl.res_slot = hsh_pkg::SLOT_TAG;
          state_d      = ST_DONE;
          case (sts_i.cmd)
            hsh_pkg::CMD_INSERT: begin
              ctl.wr_op      = hsh_pkg::WR_UPDATE;
              ctl.res_status = hsh_pkg::STAT_PRESENT;
            end
            hsh_pkg::CMD_REMOVE: begin
              ctl.wr_op       = hsh_pkg::WR_ZERO_TAG;
              ctl.cnt_op      = hsh_pkg::CNT_DEC;
              ctl.res_status  = hsh_pkg::STAT_FOUND;
              ctl.res_val_hit = 1'b1;
            end
            default: begin
              ctl.res_status  = hsh_pkg::STAT_FOUND;
              ctl.res_val_hit = 1'b1;
            end
          endcase
        end else if (sts_i.rvalid && sts_i.last) begin
          if (sts_i.cmd == hsh_pkg::CMD_INSERT) begin
            ctl.scan_start = 1'b1;
            ctl.scan_mode  = hsh_pkg::SCAN_FREE;
            state_d        = ST_FREE;
          end else begin
            ctl.res_load   = 1'b1;
            ctl.res_status = hsh_pkg::STAT_ABSENT;
            state_d        = ST_DONE;
          end
        end
      end
      ST_FREE: begin
        ctl.scan_en = 1'b1;
        if (sts_i.rvalid && sts_i.hit) begin
          ctl.pos_from_tag = 1'b1;
          state_d          = ST_CHECK;
        end else if (sts_i.rvalid && sts_i.last) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = hsh_pkg::STAT_FULL;
          state_d        = ST_DONE;
        end
      end
      ST_CHECK: begin
        if (sts_i.far) begin
          ctl.scan_start = 1'b1;
          ctl.scan_mode  = hsh_pkg::SCAN_HOP;
          state_d        = ST_HOP;
        end else begin
          ctl.wr_op      = hsh_pkg::WR_NEW;
          ctl.cnt_op     = hsh_pkg::CNT_INC;
          ctl.res_load   = 1'b1;
          ctl.res_status = hsh_pkg::STAT_INSERTED;
          ctl.res_slot   = hsh_pkg::SLOT_POS;
          state_d        = ST_DONE;
        end
      end
      ST_HOP: begin
        ctl.scan_en = 1'b1;
        if (sts_i.rvalid && sts_i.hit) begin
          ctl.wr_op        = hsh_pkg::WR_MOVE;
          ctl.src_from_tag = 1'b1;
          state_d          = ST_CLR_SRC;
        end else if (sts_i.rvalid && sts_i.last) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = hsh_pkg::STAT_FULL;
          state_d        = ST_DONE;
        end
      end
      ST_CLR_SRC: begin
        ctl.wr_op        = hsh_pkg::WR_ZERO_SRC;
        ctl.pos_from_src = 1'b1;
        state_d          = ST_CHECK;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          ctl.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output beat valid: set on load, drop when taken
  always_comb begin
    if (ctl.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hw/rtl/hopscotch_int_hash_table.sv
// Insert scans the neighborhood for the key, then the probe window for a free slot, then moves
// keys until the free slot lies in the key's neighborhood; lookup and remove scan the
// neighborhood; clear sweeps the whole store. One slot is read per cycle from the single store
// read port while a scan runs. One operation is in flight at a time; the next request is taken
// in the cycle after a result is loaded for output, also while that result waits.
// After reset the store is swept to empty before a request is taken.
`timescale 1ns / 1ps

module hopscotch_int_hash_table #(
  parameter int unsigned TABLE_SLOTS  = 1024,
  parameter int unsigned NEIGHBORHOOD = 32,
  parameter int unsigned PROBE_WINDOW = 256
) (
  input logic      clk_i,
  input logic      rst_ni,
  hsh_req_if.sink  req_i,
  hsh_rsp_if.source rsp_o
);

  hsh_pkg::ctl_t ctl;
  hsh_pkg::sts_t sts;

  // Sequencer
  hsh_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Store and registers
  hsh_datapath #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .NEIGHBORHOOD (NEIGHBORHOOD),
    .PROBE_WINDOW (PROBE_WINDOW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_command_i (req_i.command),
    .req_key_i     (req_i.key),
    .req_value_i   (req_i.value_in),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .out_status_o  (rsp_o.status),
    .out_slot_o    (rsp_o.slot),
    .out_value_o   (rsp_o.value_out),
    .out_occ_o     (rsp_o.occupancy)
  );

endmodule
